/* hdl/svang_pkg.sv */
`timescale 1ns / 1ps
package svang_pkg;

	localparam int FRAC_BITS_DEFAULT = 16;

	localparam logic [1:0] REG_ANGLE_IN_DEGREES = 2'd0;
	localparam logic [1:0] REG_SIGNED_RESULT    = 2'd1;
	localparam logic [1:0] REG_MIN_LENGTH       = 2'd2;

	localparam int SQ1_CELLS    = 32;
	localparam int DIV_CELLS    = 30;
	localparam int SQ2_CELLS    = 31;
	localparam int CORDIC_CELLS = 30;

	localparam logic [31:0] Q30_PI          = 32'd3373259426;
	localparam logic [29:0] DEG_PER_RAD_Q24 = 30'd961263669;

	typedef struct packed {
		logic signed [31:0] from_x;
		logic signed [31:0] from_y;
		logic signed [31:0] from_z;
		logic signed [31:0] to_x;
		logic signed [31:0] to_y;
		logic signed [31:0] to_z;
		logic signed [31:0] axis_x;
		logic signed [31:0] axis_y;
		logic signed [31:0] axis_z;
	} svang_query_t;

	typedef struct packed {
		logic signed [24:0] angle;
		logic               degenerate;
	} svang_result_t;

	function automatic logic [29:0] svang_atan(input int unsigned idx);
		logic [29:0] v;
		case (idx)
			0: v = 30'd843314856;
			1: v = 30'd497837829;
			2: v = 30'd263043836;
			3: v = 30'd133525158;
			4: v = 30'd67021686;
			5: v = 30'd33543515;
			6: v = 30'd16775850;
			7: v = 30'd8388437;
			8: v = 30'd4194282;
			9: v = 30'd2097149;
			10: v = 30'd1048575;
			11: v = 30'd524287;
			12: v = 30'd262143;
			13: v = 30'd131071;
			14: v = 30'd65535;
			15: v = 30'd32767;
			16: v = 30'd16383;
			17: v = 30'd8191;
			18: v = 30'd4095;
			19: v = 30'd2047;
			20: v = 30'd1023;
			21: v = 30'd511;
			22: v = 30'd255;
			23: v = 30'd127;
			24: v = 30'd63;
			25: v = 30'd31;
			26: v = 30'd15;
			27: v = 30'd8;
			28: v = 30'd4;
			29: v = 30'd2;
			default: v = 30'd0;
		endcase
		return v;
	endfunction

endpackage

/* hdl/svang_sqrt_cell.sv */
`timescale 1ns / 1ps
module svang_sqrt_cell import svang_pkg::*; #(
	parameter int W       = 64,
	parameter int BIT_POS = 62,
	parameter int SW      = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          up_valid,
	input  logic [W-1:0]  up_rad,
	input  logic [W-1:0]  up_res,
	input  logic [SW-1:0] up_side,
	output logic          dn_valid,
	output logic [W-1:0]  dn_rad,
	output logic [W-1:0]  dn_res,
	output logic [SW-1:0] dn_side
);

	localparam logic [W-1:0] BIT_V = {{(W-1){1'b0}}, 1'b1} << BIT_POS;

	logic [W-1:0] trial;
	logic [W-1:0] nrad;
	logic [W-1:0] nres;
	logic         valid_q;
	logic [W-1:0] rad_q;
	logic [W-1:0] res_q;
	logic [SW-1:0] side_q;

	always_comb begin
		trial = up_res + BIT_V;
		if (up_rad >= trial) begin
			nrad = up_rad - trial;
			nres = (up_res >> 1) + BIT_V;
		end else begin
			nrad = up_rad;
			nres = up_res >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_q  <= nrad;
			res_q  <= nres;
			side_q <= up_side;
		end
	end

	assign dn_valid = valid_q;
	assign dn_rad   = rad_q;
	assign dn_res   = res_q;
	assign dn_side  = side_q;

endmodule

/* hdl/svang_div_cell.sv */
`timescale 1ns / 1ps
module svang_div_cell import svang_pkg::*; #(
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          up_valid,
	input  logic [63:0]   up_r,
	input  logic [63:0]   up_d,
	input  logic [29:0]   up_c,
	input  logic [SW-1:0] up_side,
	output logic          dn_valid,
	output logic [63:0]   dn_r,
	output logic [63:0]   dn_d,
	output logic [29:0]   dn_c,
	output logic [SW-1:0] dn_side
);

	logic [64:0]   rr;
	logic [64:0]   diff;
	logic [63:0]   nr;
	logic [29:0]   nc;
	logic          valid_q;
	logic [63:0]   r_q;
	logic [63:0]   d_q;
	logic [29:0]   c_q;
	logic [SW-1:0] side_q;

	always_comb begin
		rr   = {up_r, 1'b0};
		diff = rr - {1'b0, up_d};
		if (rr >= {1'b0, up_d}) begin
			nr = diff[63:0];
			nc = {up_c[28:0], 1'b1};
		end else begin
			nr = rr[63:0];
			nc = {up_c[28:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_q    <= nr;
			d_q    <= up_d;
			c_q    <= nc;
			side_q <= up_side;
		end
	end

	assign dn_valid = valid_q;
	assign dn_r     = r_q;
	assign dn_d     = d_q;
	assign dn_c     = c_q;
	assign dn_side  = side_q;

endmodule

/* hdl/svang_cordic_cell.sv */
`timescale 1ns / 1ps
module svang_cordic_cell import svang_pkg::*; #(
	parameter int STEP = 0,
	parameter int SW   = 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               up_valid,
	input  logic signed [32:0] up_x,
	input  logic signed [32:0] up_y,
	input  logic signed [32:0] up_z,
	input  logic [SW-1:0]      up_side,
	output logic               dn_valid,
	output logic signed [32:0] dn_x,
	output logic signed [32:0] dn_y,
	output logic signed [32:0] dn_z,
	output logic [SW-1:0]      dn_side
);

	localparam logic signed [32:0] ATAN = $signed({3'b000, svang_atan(STEP)});

	logic signed [32:0] dx;
	logic signed [32:0] dy;
	logic signed [32:0] nx;
	logic signed [32:0] ny;
	logic signed [32:0] nz;
	logic               valid_q;
	logic signed [32:0] x_q;
	logic signed [32:0] y_q;
	logic signed [32:0] z_q;
	logic [SW-1:0]      side_q;

	always_comb begin
		dx = up_y >>> STEP;
		dy = up_x >>> STEP;
		if (!up_y[32] && (up_y != '0)) begin
			nx = up_x + dx;
			ny = up_y - dy;
			nz = up_z + ATAN;
		end else begin
			nx = up_x - dx;
			ny = up_y + dy;
			nz = up_z - ATAN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_q    <= nx;
			y_q    <= ny;
			z_q    <= nz;
			side_q <= up_side;
		end
	end

	assign dn_valid = valid_q;
	assign dn_x     = x_q;
	assign dn_y     = y_q;
	assign dn_z     = z_q;
	assign dn_side  = side_q;

endmodule

/* hdl/vector3_signed_angle_unit.sv */
`timescale 1ns / 1ps
// channel   | handshake                   | payload
// query     | query_valid / query_ready   | query  (svang_query_t)
// result    | result_valid / result_ready | result (svang_result_t)
// config    | psel penable pwrite pready  | paddr pwdata prdata
//
// one item per cycle sustained while query_ready is high; the whole pipeline holds when it is low
// the pipeline is built from the cell rows: two 32-cell square roots, a 30-cell divider,
// a 31-cell square root and a 30-cell cordic row, plus 13 glue stages
// a two-entry output buffer parts the sides; query_ready drops only when it is full
// arst_n clears all valid bits and the buffer count and sets the config registers to their defaults
module vector3_signed_angle_unit import svang_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          query_valid,
	output logic          query_ready,
	input  svang_query_t  query,
	output logic          result_valid,
	input  logic          result_ready,
	output svang_result_t result,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [3:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);

	localparam int SH = 30 - FRAC_BITS;
	localparam logic [39:0] RND = (40'd1 << SH) >> 1;
	localparam logic [30:0] Q30_ONE = 31'd1 << 30;
	localparam logic [61:0] Q60_ONE = 62'd1 << 60;
	localparam logic [62:0] DEG_RND = 63'd1 << 23;

	logic        deg_q;
	logic        sgn_q;
	logic [16:0] minlen_q;
	logic        en;
	logic [1:0]  cnt_q;

	// config
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deg_q    <= 1'b0;
			sgn_q    <= 1'b1;
			minlen_q <= 17'd1;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				REG_ANGLE_IN_DEGREES: deg_q    <= pwdata[0];
				REG_SIGNED_RESULT:    sgn_q    <= pwdata[0];
				REG_MIN_LENGTH:       minlen_q <= pwdata[16:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_ANGLE_IN_DEGREES: prdata = {31'd0, deg_q};
			REG_SIGNED_RESULT:    prdata = {31'd0, sgn_q};
			REG_MIN_LENGTH:       prdata = {15'd0, minlen_q};
			default:              prdata = 32'd0;
		endcase
	end

	assign en          = (cnt_q != 2'd2);
	assign query_ready = en;

	// s1: products
	logic               v_s1;
	logic signed [63:0] ax2_s1, ay2_s1, az2_s1, bx2_s1, by2_s1, bz2_s1;
	logic signed [63:0] xx_s1, yy_s1, zz_s1;
	logic signed [63:0] aybz_s1, azby_s1, azbx_s1, axbz_s1, axby_s1, aybx_s1;
	logic signed [31:0] kx_s1, ky_s1, kz_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			ax2_s1  <= query.from_x * query.from_x;
			ay2_s1  <= query.from_y * query.from_y;
			az2_s1  <= query.from_z * query.from_z;
			bx2_s1  <= query.to_x * query.to_x;
			by2_s1  <= query.to_y * query.to_y;
			bz2_s1  <= query.to_z * query.to_z;
			xx_s1   <= query.from_x * query.to_x;
			yy_s1   <= query.from_y * query.to_y;
			zz_s1   <= query.from_z * query.to_z;
			aybz_s1 <= query.from_y * query.to_z;
			azby_s1 <= query.from_z * query.to_y;
			azbx_s1 <= query.from_z * query.to_x;
			axbz_s1 <= query.from_x * query.to_z;
			axby_s1 <= query.from_x * query.to_y;
			aybx_s1 <= query.from_y * query.to_x;
			kx_s1   <= query.axis_x;
			ky_s1   <= query.axis_y;
			kz_s1   <= query.axis_z;
		end
	end

	// s2: sums and cross differences
	logic               v_s2;
	logic [63:0]        sqa_s2, sqb_s2;
	logic signed [65:0] dot_s2;
	logic signed [64:0] cr1_s2, cr2_s2, cr3_s2;
	logic signed [31:0] kx_s2, ky_s2, kz_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			sqa_s2 <= ax2_s1 + ay2_s1 + az2_s1;
			sqb_s2 <= bx2_s1 + by2_s1 + bz2_s1;
			dot_s2 <= 66'(xx_s1) + 66'(yy_s1) + 66'(zz_s1);
			cr1_s2 <= 65'(aybz_s1) - 65'(azby_s1);
			cr2_s2 <= 65'(azbx_s1) - 65'(axbz_s1);
			cr3_s2 <= 65'(axby_s1) - 65'(aybx_s1);
			kx_s2  <= kx_s1;
			ky_s2  <= ky_s1;
			kz_s2  <= kz_s1;
		end
	end

	// s3: dot magnitude, triple product partials
	logic               v_s3;
	logic [63:0]        sqa_s3, sqb_s3, dotmag_s3;
	logic               dneg_s3;
	logic signed [65:0] pl1_s3, pl2_s3, pl3_s3;
	logic signed [63:0] ph1_s3, ph2_s3, ph3_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			sqa_s3    <= sqa_s2;
			sqb_s3    <= sqb_s2;
			dneg_s3   <= dot_s2[65];
			dotmag_s3 <= dot_s2[65] ? 64'(-dot_s2) : dot_s2[63:0];
			pl1_s3    <= $signed({1'b0, cr1_s2[32:0]}) * kx_s2;
			pl2_s3    <= $signed({1'b0, cr2_s2[32:0]}) * ky_s2;
			pl3_s3    <= $signed({1'b0, cr3_s2[32:0]}) * kz_s2;
			ph1_s3    <= $signed(cr1_s2[64:33]) * kx_s2;
			ph2_s3    <= $signed(cr2_s2[64:33]) * ky_s2;
			ph3_s3    <= $signed(cr3_s2[64:33]) * kz_s2;
		end
	end

	// s4: partial sums
	logic               v_s4;
	logic [63:0]        sqa_s4, sqb_s4, dotmag_s4;
	logic               dneg_s4;
	logic signed [67:0] lo_s4;
	logic signed [65:0] hi_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			sqa_s4    <= sqa_s3;
			sqb_s4    <= sqb_s3;
			dotmag_s4 <= dotmag_s3;
			dneg_s4   <= dneg_s3;
			lo_s4     <= 68'(pl1_s3) + 68'(pl2_s3) + 68'(pl3_s3);
			hi_s4     <= 66'(ph1_s3) + 66'(ph2_s3) + 66'(ph3_s3);
		end
	end

	// s5: triple product sign
	logic               v_s5;
	logic [63:0]        sqa_s5, sqb_s5, dotmag_s5;
	logic               dneg_s5, tneg_s5;
	logic signed [99:0] tsum;

	assign tsum = (100'(hi_s4) <<< 33) + 100'(lo_s4);

	always_ff @(posedge clk) begin
		if (en) begin
			sqa_s5    <= sqa_s4;
			sqb_s5    <= sqb_s4;
			dotmag_s5 <= dotmag_s4;
			dneg_s5   <= dneg_s4;
			tneg_s5   <= tsum[99];
		end
	end

	// vector lengths
	logic        a_v    [0:SQ1_CELLS];
	logic [63:0] a_rad  [0:SQ1_CELLS];
	logic [63:0] a_res  [0:SQ1_CELLS];
	logic [63:0] a_side [0:SQ1_CELLS];
	logic        b_v    [0:SQ1_CELLS];
	logic [63:0] b_rad  [0:SQ1_CELLS];
	logic [63:0] b_res  [0:SQ1_CELLS];
	logic [1:0]  b_side [0:SQ1_CELLS];

	assign a_v[0]    = v_s5;
	assign a_rad[0]  = sqa_s5;
	assign a_res[0]  = '0;
	assign a_side[0] = dotmag_s5;
	assign b_v[0]    = v_s5;
	assign b_rad[0]  = sqb_s5;
	assign b_res[0]  = '0;
	assign b_side[0] = {dneg_s5, tneg_s5};

	genvar gi;
	for (gi = 0; gi < SQ1_CELLS; gi++) begin : g_len
		svang_sqrt_cell #(.W(64), .BIT_POS(62 - 2 * gi), .SW(64)) u_sqa (
			.clk(clk), .arst_n(arst_n), .en(en),
			.up_valid(a_v[gi]), .up_rad(a_rad[gi]), .up_res(a_res[gi]),
			.up_side(a_side[gi]),
			.dn_valid(a_v[gi+1]), .dn_rad(a_rad[gi+1]), .dn_res(a_res[gi+1]),
			.dn_side(a_side[gi+1])
		);
		svang_sqrt_cell #(.W(64), .BIT_POS(62 - 2 * gi), .SW(2)) u_sqb (
			.clk(clk), .arst_n(arst_n), .en(en),
			.up_valid(b_v[gi]), .up_rad(b_rad[gi]), .up_res(b_res[gi]),
			.up_side(b_side[gi]),
			.dn_valid(b_v[gi+1]), .dn_rad(b_rad[gi+1]), .dn_res(b_res[gi+1]),
			.dn_side(b_side[gi+1])
		);
	end

	// s6: length product, degenerate test
	logic        v_s6;
	logic [31:0] la, lb;
	logic [63:0] r_s6, d_s6;
	logic        degen_s6, dneg_s6, tneg_s6;

	assign la = a_res[SQ1_CELLS][31:0];
	assign lb = b_res[SQ1_CELLS][31:0];

	always_ff @(posedge clk) begin
		if (en) begin
			r_s6     <= a_side[SQ1_CELLS];
			d_s6     <= la * lb;
			degen_s6 <= (la == 32'd0) || (lb == 32'd0) ||
			            (la < {15'd0, minlen_q}) || (lb < {15'd0, minlen_q});
			dneg_s6  <= b_side[SQ1_CELLS][1];
			tneg_s6  <= b_side[SQ1_CELLS][0];
		end
	end

	// s7: ratio at or above one
	logic        v_s7;
	logic [63:0] r_s7, d_s7;
	logic        ge_s7, degen_s7, dneg_s7, tneg_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			r_s7     <= r_s6;
			d_s7     <= d_s6;
			ge_s7    <= (r_s6 >= d_s6);
			degen_s7 <= degen_s6;
			dneg_s7  <= dneg_s6;
			tneg_s7  <= tneg_s6;
		end
	end

	// cosine division
	logic        q_v    [0:DIV_CELLS];
	logic [63:0] q_r    [0:DIV_CELLS];
	logic [63:0] q_d    [0:DIV_CELLS];
	logic [29:0] q_c    [0:DIV_CELLS];
	logic [3:0]  q_side [0:DIV_CELLS];

	assign q_v[0]    = v_s7;
	assign q_r[0]    = r_s7;
	assign q_d[0]    = d_s7;
	assign q_c[0]    = '0;
	assign q_side[0] = {ge_s7, degen_s7, dneg_s7, tneg_s7};

	for (gi = 0; gi < DIV_CELLS; gi++) begin : g_div
		svang_div_cell #(.SW(4)) u_div (
			.clk(clk), .arst_n(arst_n), .en(en),
			.up_valid(q_v[gi]), .up_r(q_r[gi]), .up_d(q_d[gi]), .up_c(q_c[gi]),
			.up_side(q_side[gi]),
			.dn_valid(q_v[gi+1]), .dn_r(q_r[gi+1]), .dn_d(q_d[gi+1]), .dn_c(q_c[gi+1]),
			.dn_side(q_side[gi+1])
		);
	end

	// s8..s10: 1 - cos^2
	logic        v_s8, v_s9, v_s10;
	logic [30:0] c_s8, c_s9, c_s10;
	logic [2:0]  fl_s8, fl_s9, fl_s10;
	logic [61:0] csq_s9, rad_s10;

	always_ff @(posedge clk) begin
		if (en) begin
			c_s8   <= q_side[DIV_CELLS][3] ? Q30_ONE : {1'b0, q_c[DIV_CELLS]};
			fl_s8  <= q_side[DIV_CELLS][2:0];
			c_s9   <= c_s8;
			csq_s9 <= c_s8 * c_s8;
			fl_s9  <= fl_s8;
			c_s10  <= c_s9;
			rad_s10 <= Q60_ONE - csq_s9;
			fl_s10 <= fl_s9;
		end
	end

	// sine by square root
	logic        s_v    [0:SQ2_CELLS];
	logic [61:0] s_rad  [0:SQ2_CELLS];
	logic [61:0] s_res  [0:SQ2_CELLS];
	logic [33:0] s_side [0:SQ2_CELLS];

	assign s_v[0]    = v_s10;
	assign s_rad[0]  = rad_s10;
	assign s_res[0]  = '0;
	assign s_side[0] = {c_s10, fl_s10};

	for (gi = 0; gi < SQ2_CELLS; gi++) begin : g_sin
		svang_sqrt_cell #(.W(62), .BIT_POS(60 - 2 * gi), .SW(34)) u_sq (
			.clk(clk), .arst_n(arst_n), .en(en),
			.up_valid(s_v[gi]), .up_rad(s_rad[gi]), .up_res(s_res[gi]),
			.up_side(s_side[gi]),
			.dn_valid(s_v[gi+1]), .dn_rad(s_rad[gi+1]), .dn_res(s_res[gi+1]),
			.dn_side(s_side[gi+1])
		);
	end

	// cordic vectoring
	logic               k_v    [0:CORDIC_CELLS];
	logic signed [32:0] k_x    [0:CORDIC_CELLS];
	logic signed [32:0] k_y    [0:CORDIC_CELLS];
	logic signed [32:0] k_z    [0:CORDIC_CELLS];
	logic [3:0]         k_side [0:CORDIC_CELLS];

	assign k_v[0]    = s_v[SQ2_CELLS];
	assign k_x[0]    = $signed({2'b00, s_side[SQ2_CELLS][33:3]});
	assign k_y[0]    = $signed({2'b00, s_res[SQ2_CELLS][30:0]});
	assign k_z[0]    = '0;
	assign k_side[0] = {(s_res[SQ2_CELLS] == '0), s_side[SQ2_CELLS][2:0]};

	for (gi = 0; gi < CORDIC_CELLS; gi++) begin : g_cordic
		svang_cordic_cell #(.STEP(gi), .SW(4)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.up_valid(k_v[gi]), .up_x(k_x[gi]), .up_y(k_y[gi]), .up_z(k_z[gi]),
			.up_side(k_side[gi]),
			.dn_valid(k_v[gi+1]), .dn_x(k_x[gi+1]), .dn_y(k_y[gi+1]), .dn_z(k_z[gi+1]),
			.dn_side(k_side[gi+1])
		);
	end

	// s11..s13: mirror, degrees, rounding
	logic        v_s11, v_s12, v_s13;
	logic [31:0] zpos;
	logic [31:0] a_s11, a_s12;
	logic [61:0] prod_s12;
	logic [1:0]  fl_s11, fl_s12, fl_s13;
	logic [62:0] degsum;
	logic [39:0] pre;
	logic [39:0] mag_s13;

	assign zpos = (k_side[CORDIC_CELLS][3] || k_z[CORDIC_CELLS][32]) ? 32'd0 :
	              k_z[CORDIC_CELLS][31:0];
	assign degsum = 63'(prod_s12) + DEG_RND;
	assign pre = deg_q ? 40'(degsum >> 24) : 40'(a_s12);

	always_ff @(posedge clk) begin
		if (en) begin
			a_s11    <= k_side[CORDIC_CELLS][1] ? (Q30_PI - zpos) : zpos;
			fl_s11   <= {k_side[CORDIC_CELLS][2], k_side[CORDIC_CELLS][0]};
			a_s12    <= a_s11;
			prod_s12 <= a_s11 * DEG_PER_RAD_Q24;
			fl_s12   <= fl_s11;
			mag_s13  <= (pre + RND) >> SH;
			fl_s13   <= fl_s12;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
			v_s13 <= 1'b0;
		end else if (en) begin
			v_s1  <= query_valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= a_v[SQ1_CELLS] & b_v[SQ1_CELLS];
			v_s7  <= v_s6;
			v_s8  <= q_v[DIV_CELLS];
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= k_v[CORDIC_CELLS];
			v_s12 <= v_s11;
			v_s13 <= v_s12;
		end
	end

	// sign and saturation
	logic [39:0]   magz;
	logic          neg;
	svang_result_t fin;

	always_comb begin
		magz = fl_s13[1] ? 40'd0 : mag_s13;
		neg  = sgn_q && fl_s13[0] && (magz != 40'd0);
		fin.degenerate = fl_s13[1];
		if (neg) begin
			fin.angle = (magz > 40'd16777216) ? 25'h1000000 : 25'(-magz);
		end else begin
			fin.angle = (magz > 40'd16777215) ? 25'h0FFFFFF : 25'(magz);
		end
	end

	// output buffer
	logic          push, pop;
	logic [1:0]    wr_pos;
	svang_result_t head_q, tail_q;

	assign push   = en && v_s13;
	assign pop    = result_valid && result_ready;
	assign wr_pos = cnt_q - {1'b0, pop};

	always_ff @(posedge clk) begin
		if (push && (wr_pos == 2'd0)) begin
			head_q <= fin;
		end else if (pop) begin
			head_q <= tail_q;
		end
		if (push && (wr_pos != 2'd0)) begin
			tail_q <= fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	assign result_valid = (cnt_q != 2'd0);
	assign result       = head_q;

`ifndef SYNTH
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("output buffer count overflow");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.degenerate |-> result.angle == 25'd0)
		else $error("degenerate item with nonzero angle");

	a_full_drain: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd2 && pop |=> cnt_q == 2'd1)
		else $error("full buffer did not drain by one");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!query_ready |=> $stable(v_s13) && $stable(mag_s13))
		else $error("pipeline moved while stalled");
`endif

endmodule
